[rtl/core/nfea_pkg.sv]
// Shared constants and types of the next-fit extent allocator.
package nfea_pkg;
    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W       = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
    localparam int ADDR_W      = 48;
    localparam int ALIGN_W     = 31;
    localparam int ENT_W       = 2 * ADDR_W;
    localparam int DIV_CNT_W   = $clog2(ADDR_W);
    localparam int CFG_IDX_W   = 2;

    localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}};

    typedef logic [2:0] t_status;
    localparam t_status ST_OK          = 3'd0;
    localparam t_status ST_NO_SPACE    = 3'd1;
    localparam t_status ST_NO_NEXT     = 3'd2;
    localparam t_status ST_NOT_FREE    = 3'd3;
    localparam t_status ST_DOUBLE_FREE = 3'd4;
    localparam t_status ST_FULL        = 3'd5;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_ALLOC  = 2'd0;
    localparam t_opcode OP_CLAIM  = 2'd1;
    localparam t_opcode OP_FREE   = 2'd2;
    localparam t_opcode OP_LOOKUP = 2'd3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BASE = 2'd0;
    localparam t_cfg_idx CFG_SIZE = 2'd1;
    localparam t_cfg_idx CFG_WRAP = 2'd2;
endpackage

[rtl/core/nfea_ram.sv]
// Generic single-port RAM with registered read.
module nfea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/core/next_fit_extent_allocator_top.sv]
// Top level of the next-fit extent allocator: sequencer around the extent table RAM.
// One transaction at a time; o_busy is high from acceptance until the result strobe.
// Lookup and claim read and check each scanned entry; free scans up to the insert point;
// allocate also takes a bit-serial remainder of each visited base for the alignment.
// Insert or delete reads then writes each moved entry; reset or a register write rebuilds
// the table with o_busy high; o_done lasts one cycle and cannot be stalled.
module next_fit_extent_allocator_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  nfea_pkg::t_opcode               i_opcode,
    input  logic [nfea_pkg::ADDR_W-1:0]     i_addr,
    input  logic [nfea_pkg::ADDR_W-1:0]     i_length,
    input  logic [nfea_pkg::ALIGN_W-1:0]    i_align,
    output logic                            o_done,
    output nfea_pkg::t_status               o_status,
    output logic [nfea_pkg::ADDR_W-1:0]     o_out_base,
    output logic [nfea_pkg::ADDR_W-1:0]     o_out_size,
    input  logic                            i_cfg_we,
    input  nfea_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [nfea_pkg::ADDR_W-1:0]     i_cfg_data
);
    import nfea_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_EVAL, S_DIV, S_CHECK, S_CUT,
        S_WR1, S_SH_RD, S_SH_WR, S_INS_WR, S_FIN
    } t_state;

    typedef enum logic [1:0] {SH_NONE, SH_INS, SH_DEL} t_shift;

    t_state r_state;

    // configuration and table bookkeeping
    logic [ADDR_W-1:0]  r_base, r_size;
    logic               r_wrap, r_init_pend;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_rover, r_begin;

    // transaction context
    t_opcode            r_op;
    logic [ADDR_W-1:0]  r_a, r_len;
    logic [ALIGN_W-1:0] r_align, r_rem;
    logic [CNT_W-1:0]   r_idx;
    logic [ADDR_W-1:0]  r_cur_s, r_cur_l, r_prev_s, r_prev_l, r_before, r_q;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [IDX_W-1:0]   r_k;

    // table update plan: an optional plain write, then an optional shift
    logic               r_w1;
    logic [IDX_W-1:0]   r_w1_addr;
    logic [ENT_W-1:0]   r_w1_data, r_ins_data;
    t_shift             r_sh_mode;
    logic [CNT_W-1:0]   r_sh_k, r_sh_dst, r_n;

    // result
    t_status            r_st;
    logic [ADDR_W-1:0]  r_ob, r_os;

    // RAM port
    logic               w_we;
    logic [IDX_W-1:0]   w_addr;
    logic [ENT_W-1:0]   w_wdata, w_rdata;

    nfea_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EXTENTS)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    logic [ADDR_W-1:0]  rd_s, rd_l;
    logic               c_has;
    logic [ADDR_W:0]    c_end_j, c_prev_end, c_a_len, c_need, c_used;
    logic [ADDR_W-1:0]  c_aend, c_room, c_fsz, c_iroom, c_isz;
    logic [ALIGN_W:0]   c_trial;
    logic [ALIGN_W-1:0] c_rem_nx, c_pad;
    logic [CNT_W-1:0]   c_rov_nx, c_rov_ins;
    logic [IDX_W-1:0]   c_rov_del, c_rov_dec;
    logic               c_front, c_back;

    always_comb begin
        rd_s       = w_rdata[ENT_W-1:ADDR_W];
        rd_l       = w_rdata[ADDR_W-1:0];
        c_has      = r_idx < r_count;
        c_end_j    = {1'b0, rd_s} + {1'b0, rd_l};
        c_prev_end = {1'b0, r_prev_s} + {1'b0, r_prev_l};
        c_a_len    = {1'b0, r_a} + {1'b0, r_len};
        c_aend     = r_a + r_len;
        c_room     = ADDR_MASK - i_addr;
        c_fsz      = (i_length > c_room) ? c_room : i_length;
        c_iroom    = ADDR_MASK - r_base;
        c_isz      = (r_size > c_iroom) ? c_iroom : r_size;
        // one restoring remainder step
        c_trial    = {r_rem, r_q[ADDR_W-1]};
        if (c_trial >= {1'b0, r_align}) begin
            c_rem_nx = ALIGN_W'(c_trial - {1'b0, r_align});
        end else begin
            c_rem_nx = c_trial[ALIGN_W-1:0];
        end
        c_pad      = (r_rem != '0) ? (r_align - r_rem) : '0;
        c_need     = {1'b0, r_len} + (ADDR_W+1)'(c_pad);
        c_used     = {1'b0, r_before} + {1'b0, r_len};
        c_front    = r_before != '0;
        c_back     = {1'b0, r_cur_l} > c_used;
        c_rov_nx   = {1'b0, r_rover} + CNT_W'(1);
        // rover follows its extent across an insert or a delete
        if (r_count == '0) begin
            c_rov_ins = '0;
        end else if ({1'b0, r_rover} >= r_sh_k) begin
            c_rov_ins = c_rov_nx;
        end else begin
            c_rov_ins = {1'b0, r_rover};
        end
        c_rov_dec = ({1'b0, r_rover} > r_sh_k) ? (r_rover - IDX_W'(1)) : r_rover;
        c_rov_del = ({1'b0, c_rov_dec} >= (r_count - CNT_W'(1))) ? '0 : c_rov_dec;
    end

    // RAM access per state
    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_idx[IDX_W-1:0];
        w_wdata = r_w1_data;
        case (r_state)
            S_IDLE: begin
                if (r_init_pend) begin
                    w_we    = 1'b1;
                    w_addr  = '0;
                    w_wdata = {r_base, c_isz};
                end
            end
            S_WR1: begin
                w_we   = r_w1;
                w_addr = r_w1_addr;
            end
            S_SH_RD: begin
                if (r_sh_mode == SH_INS) begin
                    w_addr = IDX_W'(r_sh_dst - CNT_W'(1));
                end else begin
                    w_addr = IDX_W'(r_sh_dst + CNT_W'(1));
                end
            end
            S_SH_WR: begin
                w_we    = 1'b1;
                w_addr  = r_sh_dst[IDX_W-1:0];
                w_wdata = w_rdata;
            end
            S_INS_WR: begin
                w_we    = 1'b1;
                w_addr  = r_sh_k[IDX_W-1:0];
                w_wdata = r_ins_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_size      <= '0;
            r_wrap      <= 1'b0;
            r_init_pend <= 1'b1;
            r_count     <= '0;
            r_rover     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (r_init_pend) begin
                        // rebuild: one extent over the range, or an empty table
                        r_init_pend <= 1'b0;
                        r_count     <= (c_isz != '0) ? CNT_W'(1) : '0;
                        r_rover     <= '0;
                    end else if (i_start) begin
                        r_op      <= i_opcode;
                        r_a       <= i_addr;
                        r_len     <= (i_opcode == OP_FREE) ? c_fsz : i_length;
                        r_align   <= (i_align == '0) ? ALIGN_W'(1) : i_align;
                        r_os      <= '0;
                        r_ob      <= '0;
                        r_st      <= ST_OK;
                        r_w1      <= 1'b0;
                        r_sh_mode <= SH_NONE;
                        r_idx     <= '0;
                        case (i_opcode)
                            OP_ALLOC: begin
                                if (r_count == '0) begin
                                    r_st    <= ST_NO_SPACE;
                                    r_state <= S_FIN;
                                end else begin
                                    if ({1'b0, r_rover} >= r_count) begin
                                        r_rover <= '0;
                                        r_begin <= '0;
                                        r_idx   <= '0;
                                    end else begin
                                        r_begin <= r_rover;
                                        r_idx   <= {1'b0, r_rover};
                                    end
                                    r_state <= S_RD;
                                end
                            end
                            OP_FREE: begin
                                r_state <= S_RD;
                            end
                            default: begin
                                if (r_count == '0) begin
                                    r_st    <= ST_NOT_FREE;
                                    r_state <= S_FIN;
                                end else begin
                                    r_ob    <= i_addr;
                                    r_state <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    case (r_op)
                        OP_ALLOC: begin
                            r_cur_s   <= rd_s;
                            r_cur_l   <= rd_l;
                            r_q       <= rd_s;
                            r_rem     <= '0;
                            r_div_cnt <= '0;
                            r_state   <= S_DIV;
                        end
                        OP_CLAIM: begin
                            if (rd_s <= r_a && c_a_len <= c_end_j) begin
                                r_k      <= r_idx[IDX_W-1:0];
                                r_cur_s  <= rd_s;
                                r_cur_l  <= rd_l;
                                r_before <= r_a - rd_s;
                                r_state  <= S_CUT;
                            end else if (r_idx + CNT_W'(1) >= r_count) begin
                                r_st    <= ST_NOT_FREE;
                                r_state <= S_FIN;
                            end else begin
                                r_idx   <= r_idx + CNT_W'(1);
                                r_state <= S_RD;
                            end
                        end
                        OP_LOOKUP: begin
                            if (rd_s <= r_a && {1'b0, r_a} <= c_end_j) begin
                                r_ob    <= rd_s;
                                r_os    <= rd_l;
                                r_state <= S_FIN;
                            end else if (r_idx + CNT_W'(1) >= r_count) begin
                                r_st    <= ST_NOT_FREE;
                                r_state <= S_FIN;
                            end else begin
                                r_idx   <= r_idx + CNT_W'(1);
                                r_state <= S_RD;
                            end
                        end
                        default: begin
                            // free: r_idx is the entry after the insert point
                            if (c_has && rd_s <= r_a && {1'b0, r_a} < c_end_j) begin
                                r_st    <= ST_DOUBLE_FREE;
                                r_state <= S_FIN;
                            end else if (r_idx != '0 && c_prev_end == {1'b0, r_a}) begin
                                r_w1      <= 1'b1;
                                r_w1_addr <= IDX_W'(r_idx - CNT_W'(1));
                                if (c_has && c_aend == rd_s) begin
                                    r_w1_data <= {r_prev_s, r_prev_l + r_len + rd_l};
                                    r_sh_mode <= SH_DEL;
                                    r_sh_k    <= r_idx;
                                    if ({1'b0, r_rover} == r_idx) begin
                                        r_rover <= IDX_W'(r_idx - CNT_W'(1));
                                    end
                                end else begin
                                    r_w1_data <= {r_prev_s, r_prev_l + r_len};
                                end
                                r_state <= S_WR1;
                            end else if (c_has && c_aend == rd_s) begin
                                r_w1      <= 1'b1;
                                r_w1_addr <= r_idx[IDX_W-1:0];
                                r_w1_data <= {r_a, rd_l + r_len};
                                r_state   <= S_WR1;
                            end else if (!c_has || r_a < rd_s) begin
                                if (r_count >= CNT_W'(MAX_EXTENTS)) begin
                                    r_st    <= ST_FULL;
                                    r_state <= S_FIN;
                                end else begin
                                    r_sh_mode  <= SH_INS;
                                    r_sh_k     <= r_idx;
                                    r_ins_data <= {r_a, r_len};
                                    r_state    <= S_WR1;
                                end
                            end else begin
                                r_prev_s <= rd_s;
                                r_prev_l <= rd_l;
                                r_idx    <= r_idx + CNT_W'(1);
                                r_state  <= S_RD;
                            end
                        end
                    endcase
                end
                S_DIV: begin
                    r_rem     <= c_rem_nx;
                    r_q       <= {r_q[ADDR_W-2:0], 1'b0};
                    r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                    if (r_div_cnt == DIV_CNT_W'(ADDR_W - 1)) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if ({1'b0, r_cur_l} >= c_need) begin
                        r_before <= ADDR_W'(c_pad);
                        r_ob     <= r_cur_s + ADDR_W'(c_pad);
                        r_k      <= r_rover;
                        r_state  <= S_CUT;
                    end else begin
                        if (c_rov_nx >= r_count) begin
                            r_rover <= '0;
                            if (!r_wrap || r_begin == '0) begin
                                r_st    <= (r_begin == '0) ? ST_NO_SPACE : ST_NO_NEXT;
                                r_state <= S_FIN;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_RD;
                            end
                        end else begin
                            r_rover <= c_rov_nx[IDX_W-1:0];
                            if (c_rov_nx[IDX_W-1:0] == r_begin) begin
                                r_st    <= ST_NO_SPACE;
                                r_state <= S_FIN;
                            end else begin
                                r_idx   <= c_rov_nx;
                                r_state <= S_RD;
                            end
                        end
                    end
                end
                S_CUT: begin
                    // split the hit extent into its front and back rests, or delete it if none
                    r_w1_addr <= r_k;
                    r_state   <= S_WR1;
                    if (c_front && c_back) begin
                        if (r_count >= CNT_W'(MAX_EXTENTS)) begin
                            r_st    <= ST_FULL;
                            r_state <= S_FIN;
                        end else begin
                            r_w1       <= 1'b1;
                            r_w1_data  <= {r_cur_s, r_before};
                            r_sh_mode  <= SH_INS;
                            r_sh_k     <= {1'b0, r_k} + CNT_W'(1);
                            r_ins_data <= {r_cur_s + c_used[ADDR_W-1:0],
                                           r_cur_l - c_used[ADDR_W-1:0]};
                        end
                    end else if (c_front) begin
                        r_w1      <= 1'b1;
                        r_w1_data <= {r_cur_s, r_before};
                    end else if (c_back) begin
                        r_w1      <= 1'b1;
                        r_w1_data <= {r_cur_s + c_used[ADDR_W-1:0],
                                      r_cur_l - c_used[ADDR_W-1:0]};
                    end else begin
                        r_sh_mode <= SH_DEL;
                        r_sh_k    <= {1'b0, r_k};
                    end
                end
                S_WR1: begin
                    r_n <= r_count;
                    case (r_sh_mode)
                        SH_INS: begin
                            r_rover  <= c_rov_ins[IDX_W-1:0];
                            r_count  <= r_count + CNT_W'(1);
                            r_sh_dst <= r_count;
                            r_state  <= (r_count == r_sh_k) ? S_INS_WR : S_SH_RD;
                        end
                        SH_DEL: begin
                            r_rover  <= c_rov_del;
                            r_count  <= r_count - CNT_W'(1);
                            r_sh_dst <= r_sh_k;
                            r_state  <= (r_sh_k + CNT_W'(1) < r_count) ? S_SH_RD : S_FIN;
                        end
                        default: begin
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_SH_RD: begin
                    r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    if (r_sh_mode == SH_INS) begin
                        // move entries up, top first
                        if (r_sh_dst - CNT_W'(1) == r_sh_k) begin
                            r_state <= S_INS_WR;
                        end else begin
                            r_sh_dst <= r_sh_dst - CNT_W'(1);
                            r_state  <= S_SH_RD;
                        end
                    end else begin
                        // move entries down, bottom first
                        if ({1'b0, r_sh_dst} + (CNT_W+1)'(2) < {1'b0, r_n}) begin
                            r_sh_dst <= r_sh_dst + CNT_W'(1);
                            r_state  <= S_SH_RD;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_INS_WR: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // user keeps register writes to idle only; not enforced here; each rebuilds the table
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_BASE: begin
                        r_base      <= i_cfg_data;
                        r_init_pend <= 1'b1;
                    end
                    CFG_SIZE: begin
                        r_size      <= i_cfg_data;
                        r_init_pend <= 1'b1;
                    end
                    CFG_WRAP: begin
                        r_wrap      <= i_cfg_data[0];
                        r_init_pend <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_busy     = (r_state != S_IDLE) || r_init_pend;
    assign o_done     = (r_state == S_FIN);
    assign o_status   = r_st;
    assign o_out_base = (r_st == ST_OK) ? r_ob : '0;
    assign o_out_size = (r_st == ST_OK) ? r_os : '0;
endmodule
